// ===== sv/pfmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfmt_pkg: shared types and constants
// Character codes, controller/datapath command and status types, digit lookup.
// ----------------------------------------------------------------------------
package pfmt_pkg;

  localparam int unsigned PFMT_MAX_LENGTH = 32'd65535;

  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 32;
  localparam int LEN_W      = 16;
  localparam int WIDTH_W    = 4;
  localparam int DEC_DIGITS = 10;
  localparam int DIG_W      = $clog2(DEC_DIGITS);
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int BITCNT_W   = $clog2(ARG_W);

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DEC     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_HEX_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_HEX_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_PTR     = 8'h70;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h37;  // 'A' - 10

  // pointer form: fixed 8 hex digits, zero padded
  localparam logic [WIDTH_W-1:0] PTR_DIGITS = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_SETUP, ST_PFX0, ST_PFX1, ST_SIGN, ST_PAD, ST_DIGIT
  } state_t;

  typedef enum logic [3:0] {
    CK_NUL, CK_PERCENT, CK_ZERO, CK_WIDTH, CK_DEC, CK_HEX_LO, CK_HEX_UP,
    CK_PTR, CK_OTHER
  } char_kind_t;

  typedef enum logic [2:0] {
    SP_NONE, SP_OPEN, SP_ZERO, SP_WIDTH, SP_CLOSE, SP_RESET
  } spec_op_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_INPUT, EM_TERM, EM_ZERO, EM_X, EM_SIGN, EM_PAD, EM_DIGIT
  } emit_t;

  typedef struct packed {
    logic     accept;
    spec_op_t spec_op;
    logic     load_conv;
    logic     conv_step;
    logic     setup;
    emit_t    emit;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       in_spec;
    char_kind_t kind;
    logic       slot_free;
    logic       conv_done;
    logic       neg;
    logic       pad_zero;
    logic       dig_last;
  } stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {4'h0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d_ext;
    end
    return (upper ? CH_UPPER_A : CH_LOWER_A) + d_ext;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pfmt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfmt_in_if: format character channel
// One format byte plus the argument a conversion letter would consume.
// ----------------------------------------------------------------------------
interface pfmt_in_if import pfmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] fmt_char;
  logic [ARG_W-1:0]  arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface
`default_nettype wire

// ===== sv/pfmt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfmt_out_if: output character channel
// One formatted character with run/end marks and the final length.
// ----------------------------------------------------------------------------
interface pfmt_out_if import pfmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_of_run;
  logic              string_end;
  logic [LEN_W-1:0]  total_length;

  modport source (output valid, output out_char, output last_of_run,
                  output string_end, output total_length, input ready);
  modport sink   (input valid, input out_char, input last_of_run,
                  input string_end, input total_length, output ready);
endinterface
`default_nettype wire

// ===== sv/pfmt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfmt_ctrl: formatter sequencer
// Walks spec parsing, conversion, and character emission for each item.
// ----------------------------------------------------------------------------
module pfmt_ctrl import pfmt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   fire;

  assign fire = stat.in_valid && stat.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire && stat.in_spec) begin
          case (stat.kind)
            CK_DEC:    state_next = ST_CONV;
            CK_HEX_LO: state_next = ST_SETUP;
            CK_HEX_UP: state_next = ST_SETUP;
            CK_PTR:    state_next = ST_PFX0;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONV:  if (stat.conv_done) state_next = ST_SETUP;
      ST_SETUP: state_next = stat.neg ? ST_SIGN : ST_PAD;
      ST_PFX0:  if (stat.slot_free) state_next = ST_PFX1;
      ST_PFX1:  if (stat.slot_free) state_next = ST_SETUP;
      ST_SIGN:  if (stat.slot_free) state_next = ST_PAD;
      ST_PAD:   if (stat.pad_zero) state_next = ST_DIGIT;
      ST_DIGIT: if (stat.slot_free && stat.dig_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = stat.slot_free;
        if (fire) begin
          if (stat.kind == CK_NUL) begin
            cmd.spec_op = SP_RESET;
            cmd.emit    = EM_TERM;
            cmd.last    = 1'b1;
          end else if (!stat.in_spec) begin
            if (stat.kind == CK_PERCENT) begin
              cmd.spec_op = SP_OPEN;
            end else begin
              cmd.emit = EM_INPUT;
              cmd.last = 1'b1;
            end
          end else begin
            case (stat.kind)
              CK_ZERO:  cmd.spec_op = SP_ZERO;
              CK_WIDTH: cmd.spec_op = SP_WIDTH;
              CK_DEC, CK_HEX_LO, CK_HEX_UP, CK_PTR: begin
                cmd.spec_op   = SP_CLOSE;
                cmd.load_conv = 1'b1;
              end
              default: begin
                cmd.spec_op = SP_CLOSE;
                cmd.emit    = EM_INPUT;
                cmd.last    = 1'b1;
              end
            endcase
          end
        end
      end
      ST_CONV:  cmd.conv_step = 1'b1;
      ST_SETUP: cmd.setup = 1'b1;
      ST_PFX0:  if (stat.slot_free) cmd.emit = EM_ZERO;
      ST_PFX1:  if (stat.slot_free) cmd.emit = EM_X;
      ST_SIGN:  if (stat.slot_free) cmd.emit = EM_SIGN;
      ST_PAD:   if (stat.slot_free && !stat.pad_zero) cmd.emit = EM_PAD;
      ST_DIGIT: begin
        if (stat.slot_free) begin
          cmd.emit = EM_DIGIT;
          cmd.last = stat.dig_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pfmt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfmt_dp: formatter datapath
// Spec registers, shift-add-3 binary to BCD, digit/pad counters, output slot.
// ----------------------------------------------------------------------------
module pfmt_dp import pfmt_pkg::*; #(
  parameter int unsigned MAX_LENGTH = PFMT_MAX_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  pfmt_in_if.sink           fmt_in,
  pfmt_out_if.source        res_out
);

  localparam int CNT_W = $clog2(64'(MAX_LENGTH) + 64'd1);
  localparam int TL_W  = (CNT_W < LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);

  // spec state
  logic                in_spec;
  logic                zero_pad;
  logic [WIDTH_W-1:0]  field_width;
  logic [CNT_W-1:0]    char_count;

  // conversion state
  logic [BCD_W-1:0]    bcd;
  logic [ARG_W-1:0]    bin;
  logic [BITCNT_W-1:0] bit_cnt;
  logic                neg;
  logic                upper;
  logic [CHAR_W-1:0]   pad_char;
  logic [WIDTH_W-1:0]  conv_width;
  logic [WIDTH_W-1:0]  pad_cnt;
  logic [DIG_W-1:0]    dig_idx;

  // output slot
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic                out_end;
  logic [LEN_W-1:0]    out_len;

  char_kind_t          kind;
  logic [BCD_W-1:0]    bcd_adj;
  logic [DIG_W-1:0]    top_idx;
  logic [WIDTH_W:0]    need;
  logic [WIDTH_W-1:0]  pad_calc;
  logic [CHAR_W-1:0]   emit_char;
  logic                slot_free;

  assign slot_free = !out_valid || res_out.ready;

  always_comb begin
    if (fmt_in.fmt_char == CH_NUL) begin
      kind = CK_NUL;
    end else if (fmt_in.fmt_char == CH_PERCENT) begin
      kind = CK_PERCENT;
    end else if (fmt_in.fmt_char == CH_ZERO) begin
      kind = CK_ZERO;
    end else if (fmt_in.fmt_char >= CH_ONE && fmt_in.fmt_char <= CH_NINE) begin
      kind = CK_WIDTH;
    end else if (fmt_in.fmt_char == CH_DEC) begin
      kind = CK_DEC;
    end else if (fmt_in.fmt_char == CH_HEX_LO) begin
      kind = CK_HEX_LO;
    end else if (fmt_in.fmt_char == CH_HEX_UP) begin
      kind = CK_HEX_UP;
    end else if (fmt_in.fmt_char == CH_PTR) begin
      kind = CK_PTR;
    end else begin
      kind = CK_OTHER;
    end
  end

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                   : bcd[4*i +: 4];
    end
  end

  // highest nonzero digit; zero still prints one digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) top_idx = DIG_W'(i);
    end
  end

  assign need     = (WIDTH_W+1)'(top_idx) + (WIDTH_W+1)'(1) + (WIDTH_W+1)'(neg);
  assign pad_calc = ({1'b0, conv_width} > need)
                    ? WIDTH_W'({1'b0, conv_width} - need) : '0;

  always_comb begin
    case (cmd.emit)
      EM_INPUT: emit_char = fmt_in.fmt_char;
      EM_ZERO:  emit_char = CH_ZERO;
      EM_X:     emit_char = CH_HEX_LO;
      EM_SIGN:  emit_char = CH_MINUS;
      EM_PAD:   emit_char = pad_char;
      EM_DIGIT: emit_char = digit_char(bcd[{dig_idx, 2'b00} +: 4], upper);
      default:  emit_char = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_spec     <= 1'b0;
      zero_pad    <= 1'b0;
      field_width <= '0;
      char_count  <= '0;
    end else begin
      case (cmd.spec_op)
        SP_OPEN: begin
          in_spec     <= 1'b1;
          zero_pad    <= 1'b0;
          field_width <= '0;
        end
        SP_ZERO:  zero_pad <= 1'b1;
        SP_WIDTH: field_width <= fmt_in.fmt_char[WIDTH_W-1:0];
        SP_CLOSE: in_spec <= 1'b0;
        SP_RESET: begin
          in_spec     <= 1'b0;
          zero_pad    <= 1'b0;
          field_width <= '0;
        end
        default: in_spec <= in_spec;
      endcase
      if (cmd.spec_op == SP_RESET) begin
        char_count <= '0;
      end else if (cmd.emit != EM_NONE && char_count != CNT_MAX) begin
        char_count <= char_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_conv) begin
      neg        <= (kind == CK_DEC) && fmt_in.arg_value[ARG_W-1];
      upper      <= (kind == CK_HEX_UP);
      pad_char   <= (kind == CK_PTR || zero_pad) ? CH_ZERO : CH_SPACE;
      conv_width <= (kind == CK_PTR) ? PTR_DIGITS : field_width;
      bin        <= fmt_in.arg_value[ARG_W-1] ? (~fmt_in.arg_value + ARG_W'(1))
                                              : fmt_in.arg_value;
      bcd        <= (kind == CK_DEC) ? '0 : BCD_W'(fmt_in.arg_value);
      bit_cnt    <= '0;
    end else if (cmd.conv_step) begin
      bcd     <= {bcd_adj[BCD_W-2:0], bin[ARG_W-1]};
      bin     <= {bin[ARG_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BITCNT_W'(1);
    end
    if (cmd.setup) begin
      pad_cnt <= pad_calc;
      dig_idx <= top_idx;
    end else begin
      if (cmd.emit == EM_PAD) pad_cnt <= pad_cnt - WIDTH_W'(1);
      if (cmd.emit == EM_DIGIT) dig_idx <= dig_idx - DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      out_char <= emit_char;
      out_last <= cmd.last;
      out_end  <= (cmd.emit == EM_TERM);
      out_len  <= (cmd.emit == EM_TERM) ? LEN_W'(char_count[TL_W-1:0]) : '0;
    end
  end

  assign fmt_in.ready         = cmd.accept;
  assign res_out.valid        = out_valid;
  assign res_out.out_char     = out_char;
  assign res_out.last_of_run  = out_last;
  assign res_out.string_end   = out_end;
  assign res_out.total_length = out_len;

  assign stat.in_valid  = fmt_in.valid;
  assign stat.in_spec   = in_spec;
  assign stat.kind      = kind;
  assign stat.slot_free = slot_free;
  assign stat.conv_done = (bit_cnt == BITCNT_W'(ARG_W - 1));
  assign stat.neg       = neg;
  assign stat.pad_zero  = (pad_cnt == '0);
  assign stat.dig_last  = (dig_idx == '0);

  // the sequencer never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit != EM_NONE |-> slot_free)
    else $error("result slot overwritten");

  // terminator clears the running length
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit == EM_TERM |=> char_count == '0)
    else $error("length not cleared after terminator");

  // padding only while pad characters remain
  a_pad_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit == EM_PAD |-> pad_cnt != '0)
    else $error("pad counter underflow");

  // running length saturates
  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_MAX)
    else $error("length beyond saturation limit");

  // input is only taken while no conversion is in flight
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !cmd.conv_step && !cmd.setup)
    else $error("item taken during conversion");

endmodule
`default_nettype wire

// ===== sv/printf_integer_formatter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit: streaming integer formatter
// Parses a format string byte by byte and emits formatted characters.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                        Accept
// fmt_in    in   fmt_char[7:0], arg_value[31:0]                 valid & ready
// res_out   out  out_char[7:0], last_of_run, string_end,        valid & ready
//                total_length[15:0]
//
// Items: literal, flag, width and terminator bytes are handled in the idle state.
// A hex conversion runs setup, pad and digit states; 'p' adds the "0x" prefix.
// A decimal conversion first runs the shift-add-3 BCD conversion over all 32
// argument bits (one argument bit a cycle), then emits up to 11 characters.
// Reset: synchronous; spec state, length count, sequencer and output slot clear.
// Stalls: one output register; the sequencer holds while it is full and not
// being taken, and fmt_in is ready only between items with that slot free.
//
module printf_integer_formatter_unit import pfmt_pkg::*; #(
  parameter int unsigned MAX_LENGTH = PFMT_MAX_LENGTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pfmt_in_if.sink    fmt_in,
  pfmt_out_if.source res_out
);

  // command / status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle/parse, BCD conversion, setup, prefix, sign, pad, digit states
  pfmt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // datapath: spec registers, converter, counters and the output slot
  pfmt_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .fmt_in  (fmt_in),
    .res_out (res_out)
  );

endmodule
`default_nettype wire

// ===== tb/pfmt_format_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfmt_format_checker: output checker for the integer formatter
// Watches both channels, predicts the characters every accepted format byte
// produces, and compares each accepted output item in order.
// ----------------------------------------------------------------------------
module pfmt_format_checker import pfmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  pfmt_in_if   fmt_mon,
  pfmt_out_if  res_mon,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              term;
    logic [LEN_W-1:0]  length;
  } out_item_t;

  out_item_t expected_chars[$];
  out_item_t run_chars[$];

  logic               in_spec;
  logic               zero_pad;
  logic [WIDTH_W-1:0] field_width;
  int unsigned        written;
  int                 errors = 0;
  int                 seen = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic logic [CHAR_W-1:0] digit_of(input logic [3:0] d, input bit upper);
    if (d < 4'd10) return CH_ZERO + {4'h0, d};
    return (upper ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
  endfunction

  // one character of the current run; the length count saturates
  function automatic void emit(input logic [CHAR_W-1:0] ch);
    out_item_t r;
    r.ch     = ch;
    r.last   = 1'b0;
    r.term   = 1'b0;
    r.length = '0;
    run_chars.push_back(r);
    if (written < PFMT_MAX_LENGTH) written++;
  endfunction

  // sign first, then padding, then digits, most significant first
  function automatic void emit_number(input logic [ARG_W-1:0] mag, input int unsigned base,
                                      input bit upper, input logic [CHAR_W-1:0] pad_ch,
                                      input int width, input bit neg);
    logic [CHAR_W-1:0] digits [11];
    int nd;
    int pad;
    nd  = 0;
    pad = width - (neg ? 1 : 0);
    do begin
      digits[nd] = digit_of(4'(mag % base), upper);
      mag = mag / base;
      nd++;
      pad--;
    end while (mag != 0 && nd < 11);
    if (neg) emit(CH_MINUS);
    while (pad > 0) begin
      emit(pad_ch);
      pad--;
    end
    for (int i = nd - 1; i >= 0; i--) emit(digits[i]);
  endfunction

  function automatic void format_byte(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
    out_item_t         r;
    logic              neg;
    logic [ARG_W-1:0]  mag;
    logic [CHAR_W-1:0] pad_ch;
    run_chars.delete();
    pad_ch = zero_pad ? CH_ZERO : CH_SPACE;
    if (ch == CH_NUL) begin
      r.ch     = CH_NUL;
      r.last   = 1'b1;
      r.term   = 1'b1;
      r.length = LEN_W'(written);
      expected_chars.push_back(r);
      in_spec     = 1'b0;
      zero_pad    = 1'b0;
      field_width = '0;
      written     = 0;
      return;
    end
    if (!in_spec) begin
      if (ch == CH_PERCENT) begin
        in_spec     = 1'b1;
        zero_pad    = 1'b0;
        field_width = '0;
      end else begin
        emit(ch);
      end
    end else if (ch == CH_ZERO) begin
      zero_pad = 1'b1;
    end else if (ch >= CH_ONE && ch <= CH_NINE) begin
      field_width = WIDTH_W'(ch - CH_ZERO);
    end else begin
      in_spec = 1'b0;
      case (ch)
        CH_DEC: begin
          neg = arg[ARG_W-1];
          mag = neg ? (32'd0 - arg) : arg;
          emit_number(mag, 10, 1'b0, pad_ch, int'(field_width), neg);
        end
        CH_HEX_LO: emit_number(arg, 16, 1'b0, pad_ch, int'(field_width), 1'b0);
        CH_HEX_UP: emit_number(arg, 16, 1'b1, pad_ch, int'(field_width), 1'b0);
        CH_PTR: begin
          emit(CH_ZERO);
          emit(CH_HEX_LO);
          emit_number(arg, 16, 1'b0, CH_ZERO, int'(PTR_DIGITS), 1'b0);
        end
        default: emit(ch);
      endcase
    end
    foreach (run_chars[i]) begin
      r      = run_chars[i];
      r.last = (i == run_chars.size() - 1);
      expected_chars.push_back(r);
    end
  endfunction

  task automatic mismatch(input string field, input int unsigned want, input int unsigned got);
    if (errors < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_spec     = 1'b0;
      zero_pad    = 1'b0;
      field_width = '0;
      written     = 0;
      expected_chars.delete();
    end else begin
      // results always trail the byte that caused them, so compare first
      if (res_mon.valid && res_mon.ready) begin
        seen++;
        if (expected_chars.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected item, expected none, actual char %0h end %0b len %0d",
                     $time, res_mon.out_char, res_mon.string_end, res_mon.total_length);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== res_mon.out_char) mismatch("out_char", want.ch, res_mon.out_char);
          if (want.last !== res_mon.last_of_run)
            mismatch("last_of_run", want.last, res_mon.last_of_run);
          if (want.term !== res_mon.string_end)
            mismatch("string_end", want.term, res_mon.string_end);
          if (want.length !== res_mon.total_length)
            mismatch("total_length", want.length, res_mon.total_length);
        end
      end
      if (fmt_mon.valid && fmt_mon.ready) format_byte(fmt_mon.fmt_char, fmt_mon.arg_value);
    end
    fail_count <= errors;
    pending    <= expected_chars.size();
    checked    <= seen;
  end

endmodule

// ===== tb/tb_printf_integer_formatter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_printf_integer_formatter_unit: stimulus and verdict for the formatter
// Directed format strings, then random spec sequences with random idling on
// both channels and a long output stall. Checking is done by
// pfmt_format_checker.
// ----------------------------------------------------------------------------
module tb_printf_integer_formatter_unit;
  import pfmt_pkg::*;

  localparam int RANDOM_ITEMS = 132;
  localparam int LONG_HOLD    = 300;     // output stall, in cycles
  localparam int DRAIN_CYCLES = 80;      // > decimal conversion + 11 chars
  localparam int CYCLE_LIMIT  = 100000;

  logic clk;
  logic rst = 1'b1;

  pfmt_in_if  fmt_in();
  pfmt_out_if res_out();

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit hold_request = 1'b0;  // asks the receiver for one long stall
  bit no_idle      = 1'b0;  // both sides run without gaps while set

  printf_integer_formatter_unit dut (
    .clk     (clk),
    .rst     (rst),
    .fmt_in  (fmt_in),
    .res_out (res_out)
  );

  pfmt_format_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .fmt_mon    (fmt_in),
    .res_mon    (res_out),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop in case the block hangs on either channel
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_printf_integer_formatter_unit failed");
      $finish;
    end
  end

  // Arguments lean on the edges: zero, all ones, most negative, most positive,
  // small values that leave room for padding, and full random.
  function automatic logic [ARG_W-1:0] draw_argument();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return ARG_W'($urandom_range(0, 999));
      default: return ARG_W'($urandom());
    endcase
  endfunction

  // One format byte. A gap only ever lowers valid; back-to-back items keep it
  // high, so valid sees a single update per edge.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      fmt_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fmt_in.valid     <= 1'b1;
    fmt_in.fmt_char  <= ch;
    fmt_in.arg_value <= arg;
    do @(posedge clk); while (!fmt_in.ready);
    bytes_sent++;
  endtask

  // Receiver: a fresh random stall before each item, or the long
  // hold when the stimulus asks for it. The hold is counted here, while the
  // sender keeps offering bytes, so the output slot fills and fmt_in stalls.
  initial begin : receiver
    int stall;
    res_out.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        res_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_out.ready <= 1'b1;
      do @(posedge clk); while (!res_out.valid);
    end
  end

  initial begin : stimulus
    int                kind;
    int                n;
    int                target;
    int                hold_at;
    int                quiet_from;
    bit                hold_done;
    logic [CHAR_W-1:0] ch;

    fmt_in.valid     <= 1'b0;
    fmt_in.fmt_char  <= CH_NUL;
    fmt_in.arg_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed strings ----
    // literals: an ordinary letter and the top byte value
    send_item(8'h41, draw_argument());
    send_item(8'hFF, draw_argument());
    // %d of zero
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_DEC, 32'h0000_0000);
    // %5d of -42: sign left of the space padding
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_ONE + 8'd4, draw_argument());
    send_item(CH_DEC, 32'hFFFF_FFD6);
    // %08d of the most negative value: wider than the field, not cut
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_ZERO, draw_argument());
    send_item(CH_ONE + 8'd7, draw_argument());
    send_item(CH_DEC, 32'h8000_0000);
    // %09d of -5: zeros follow the sign
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_ZERO, draw_argument());
    send_item(CH_NINE, draw_argument());
    send_item(CH_DEC, 32'hFFFF_FFFB);
    // %50X: zero flag after the width keeps the width
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_ONE + 8'd4, draw_argument());
    send_item(CH_ZERO, draw_argument());
    send_item(CH_HEX_UP, 32'h0000_0ABC);
    // %x of all ones, %p of zero, %% copied through
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_HEX_LO, 32'hFFFF_FFFF);
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_PTR, 32'h0000_0000);
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_PERCENT, draw_argument());
    // terminator, then a terminator inside an open spec
    send_item(CH_NUL, draw_argument());
    send_item(CH_PERCENT, draw_argument());
    send_item(CH_NUL, draw_argument());

    // ---- random part ----
    // Mostly well-formed specs and literals with random content; some noise
    // bytes (any value, terminators included) break sequences up.
    target     = bytes_sent + RANDOM_ITEMS;
    hold_at    = bytes_sent + 40;
    quiet_from = bytes_sent + 90;
    hold_done  = 1'b0;
    while (bytes_sent < target) begin
      no_idle = (bytes_sent >= quiet_from && bytes_sent < quiet_from + 30);
      if (!hold_done && bytes_sent >= hold_at) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        ch = CHAR_W'($urandom_range(1, 255));
        send_item(ch, draw_argument());
      end else if (kind < 17) begin
        send_item(CH_PERCENT, draw_argument());
        if ($urandom_range(0, 1) == 1) send_item(CH_ZERO, draw_argument());
        n = $urandom_range(0, 2);
        repeat (n) begin
          ch = CH_ONE + CHAR_W'($urandom_range(0, 8));
          send_item(ch, draw_argument());
        end
        if ($urandom_range(0, 3) == 0) send_item(CH_ZERO, draw_argument());
        case ($urandom_range(0, 9))
          0, 1, 2, 3: ch = CH_DEC;
          4, 5:       ch = CH_HEX_LO;
          6:          ch = CH_HEX_UP;
          7:          ch = CH_PTR;
          8:          ch = CH_PERCENT;
          default:    ch = CHAR_W'($urandom());
        endcase
        send_item(ch, draw_argument());
      end else if (kind == 17) begin
        send_item(CH_NUL, draw_argument());
      end else begin
        send_item(CHAR_W'($urandom()), ARG_W'($urandom()));
      end
    end

    // close the last string
    no_idle = 1'b0;
    send_item(CH_NUL, draw_argument());
    fmt_in.valid <= 1'b0;

    // let every expected character arrive, then watch for strays
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d format bytes, %0d output characters; literals, flags, widths,",
             bytes_sent, checked);
    $display("  d/x/X/p and unknown conversions, terminators, a %0d-cycle output stall.",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("tb_printf_integer_formatter_unit passed");
    end else begin
      $display("tb_printf_integer_formatter_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pfmt_pkg.sv
sv/pfmt_in_if.sv
sv/pfmt_out_if.sv
sv/pfmt_ctrl.sv
sv/pfmt_dp.sv
sv/printf_integer_formatter_unit.sv
tb/pfmt_format_checker.sv
tb/tb_printf_integer_formatter_unit.sv
